>>> rtl/lsrv_pkg.sv
// Shared constants, codes and request/response types of the LIFO stack with remove-by-value.
package lsrv_pkg;

	// Storage geometry.
	localparam int DEPTH  = 16;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);

	// Field widths fixed by the interface.
	localparam int WORD_W   = 32;
	localparam int MODE_W   = 2;
	localparam int STATUS_W = 2;
	localparam int FILL_W   = 5;

	// Operation codes.
	localparam logic [MODE_W-1:0] MODE_PUSH   = 2'd0;
	localparam logic [MODE_W-1:0] MODE_POP    = 2'd1;
	localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd2;

	// Status codes.
	localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_EMPTY    = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_NOTFOUND = 2'd2;
	localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd3;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [WORD_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic [WORD_W-1:0]   data;
		logic [STATUS_W-1:0] status;
		logic [FILL_W-1:0]   fill;
	} rsp_t;

endpackage

>>> rtl/lifo_stack_with_remove_by_value.sv
// Top level of the LIFO stack with remove-by-value: sequencer, entry count and response register.
//
//   Channel | Handshake            | Payload
//   --------+----------------------+------------------------------------
//   request | req_valid/req_ready  | req  (lsrv_pkg::req_t: mode, value)
//   response| rsp_valid/rsp_ready  | rsp  (lsrv_pkg::rsp_t: data, status, fill)
//
// Steps per request, from its acceptance in the idle state to loading the result into
// the response register: push, an unused mode, or any request rejected for an empty or
// full stack finishes in the execute state; pop adds a state for the registered RAM read;
// remove reads the top entry, scans from the top down to the match, then shifts the entries
// above the match down one place, since the single RAM read port delivers one word per cycle
// both for the search and for the shift.
// Reset clears the entry count, the control state and the response registers; the RAM is not cleared,
// as no entry at or above the count is ever read. No clearing pass is needed.
// A new request is taken only while the sequencer is idle, but a finished result may
// still wait in the response register; if that register is still occupied when the
// next result is ready, the sequencer parks the result and waits for rsp_ready.
module lifo_stack_with_remove_by_value (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  lsrv_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output lsrv_pkg::rsp_t rsp
);

	localparam int ADDR_W   = lsrv_pkg::ADDR_W;
	localparam int CNT_W    = lsrv_pkg::CNT_W;
	localparam int WORD_W   = lsrv_pkg::WORD_W;
	localparam int STATUS_W = lsrv_pkg::STATUS_W;
	localparam int FILL_W   = lsrv_pkg::FILL_W;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_POP_RD,
		ST_SEARCH,
		ST_SHIFT,
		ST_RESP
	} state_t;

	state_t                   state_q, state_d;
	logic [CNT_W-1:0]         count_q, count_d;
	logic [ADDR_W-1:0]        ptr_q, ptr_d;
	lsrv_pkg::req_t           op_q;
	lsrv_pkg::rsp_t           rsp_q, park_q;
	logic                     rsp_valid_q;

	// RAM interface.
	logic                     wr_en;
	logic [ADDR_W-1:0]        wr_addr;
	logic [WORD_W-1:0]        wr_data;
	logic                     rd_en;
	logic [ADDR_W-1:0]        rd_addr;
	logic [WORD_W-1:0]        rd_data;

	// Completion of the current request.
	logic                     fin;
	logic [WORD_W-1:0]        fin_data;
	logic [STATUS_W-1:0]      fin_status;
	lsrv_pkg::rsp_t           fin_rsp;

	logic                     slot_free;
	logic [CNT_W-1:0]         count_m1;
	logic [ADDR_W-1:0]        top_idx;
	logic [CNT_W-1:0]         ptr_ext;

	lsrv_ram #(
		.DEPTH (lsrv_pkg::DEPTH),
		.WIDTH (WORD_W)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// The response register can take a new result when it is empty or being drained.
	assign slot_free = !rsp_valid_q || rsp_ready;
	assign count_m1  = count_q - CNT_W'(1);
	assign top_idx   = count_m1[ADDR_W-1:0];
	assign ptr_ext   = CNT_W'(ptr_q);

	assign req_ready = (state_q == ST_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Sequencer. The RAM is accessed at most once for reading and once for writing per
	// cycle. During the shift, the write to entry k overlaps the read of entry k+2, so
	// the same entry is never read and written in one cycle and no forwarding is needed.
	// A push and a later read of the same entry are always separated by the idle cycle.
	always_comb begin
		state_d    = state_q;
		count_d    = count_q;
		ptr_d      = ptr_q;
		wr_en      = 1'b0;
		wr_addr    = ptr_q;
		wr_data    = rd_data;
		rd_en      = 1'b0;
		rd_addr    = ptr_q;
		fin        = 1'b0;
		fin_data   = '0;
		fin_status = lsrv_pkg::STATUS_OK;

		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				case (op_q.mode)
					lsrv_pkg::MODE_PUSH: begin
						fin = 1'b1;
						if (count_q == CNT_W'(lsrv_pkg::DEPTH)) begin
							fin_status = lsrv_pkg::STATUS_FULL;
						end else begin
							wr_en   = 1'b1;
							wr_addr = count_q[ADDR_W-1:0];
							wr_data = op_q.value;
							count_d = count_q + CNT_W'(1);
						end
					end
					lsrv_pkg::MODE_POP: begin
						if (count_q == '0) begin
							fin        = 1'b1;
							fin_status = lsrv_pkg::STATUS_EMPTY;
						end else begin
							rd_en   = 1'b1;
							rd_addr = top_idx;
							count_d = count_m1;
							state_d = ST_POP_RD;
						end
					end
					lsrv_pkg::MODE_REMOVE: begin
						if (count_q == '0) begin
							fin        = 1'b1;
							fin_status = lsrv_pkg::STATUS_NOTFOUND;
						end else begin
							rd_en   = 1'b1;
							rd_addr = top_idx;
							ptr_d   = top_idx;
							state_d = ST_SEARCH;
						end
					end
					default: begin
						fin = 1'b1;
					end
				endcase
			end
			ST_POP_RD: begin
				fin      = 1'b1;
				fin_data = rd_data;
			end
			ST_SEARCH: begin
				// rd_data holds the entry at ptr_q, scanned from the top downwards.
				if (rd_data == op_q.value) begin
					if (ptr_ext + CNT_W'(1) < count_q) begin
						rd_en   = 1'b1;
						rd_addr = ptr_q + ADDR_W'(1);
						state_d = ST_SHIFT;
					end else begin
						count_d = count_m1;
						fin     = 1'b1;
					end
				end else if (ptr_q == '0) begin
					fin        = 1'b1;
					fin_status = lsrv_pkg::STATUS_NOTFOUND;
				end else begin
					rd_en   = 1'b1;
					rd_addr = ptr_q - ADDR_W'(1);
					ptr_d   = ptr_q - ADDR_W'(1);
				end
			end
			ST_SHIFT: begin
				// rd_data holds the entry just above ptr_q; move it down one place.
				wr_en   = 1'b1;
				wr_addr = ptr_q;
				wr_data = rd_data;
				if (ptr_ext + CNT_W'(2) < count_q) begin
					rd_en   = 1'b1;
					rd_addr = ptr_q + ADDR_W'(2);
					ptr_d   = ptr_q + ADDR_W'(1);
				end else begin
					count_d = count_m1;
					fin     = 1'b1;
				end
			end
			ST_RESP: begin
				if (slot_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase

		if (fin) begin
			state_d = slot_free ? ST_IDLE : ST_RESP;
		end
	end

	always_comb begin
		fin_rsp.data   = fin_data;
		fin_rsp.status = fin_status;
		fin_rsp.fill   = FILL_W'(count_d);
	end

	// State, entry count, captured request and the response register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			ptr_q       <= '0;
			op_q        <= '0;
			rsp_q       <= '0;
			park_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			ptr_q   <= ptr_d;

			if (req_valid && req_ready) begin
				op_q <= req;
			end

			if (fin) begin
				if (slot_free) begin
					rsp_q <= fin_rsp;
				end else begin
					park_q <= fin_rsp;
				end
			end else if (state_q == ST_RESP && slot_free) begin
				rsp_q <= park_q;
			end

			// A finished or parked result enters the register whenever it is free.
			if ((fin || state_q == ST_RESP) && slot_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// The entry count never goes beyond the storage depth.
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(lsrv_pkg::DEPTH))
		else $error("entry count exceeds depth");

	// A shift write always lands below the current top of the stack.
	assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && state_q == ST_SHIFT) |-> (CNT_W'(wr_addr) + CNT_W'(1) < count_q))
		else $error("shift write outside the occupied entries");

	// The stack is never written while the sequencer is idle or parked.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE || state_q == ST_RESP) |-> !wr_en)
		else $error("RAM write outside an operation");

	// A new response appears only after a request finished or a parked result drained.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(fin || state_q == ST_RESP))
		else $error("response raised without a finished request");

	// While idle, the entry count holds.
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |=> count_q == $past(count_q))
		else $error("entry count changed while idle");

endmodule

>>> rtl/lsrv_ram.sv
// Simple dual-port synchronous RAM with one write port and a registered read port.
module lsrv_ram #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 32,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Read data is held until the next read is issued.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

>>> tb/lifo_stack_with_remove_by_value_tb.sv
// Self-checking testbench for the LIFO stack with remove-by-value: random and directed requests.
module lifo_stack_with_remove_by_value_tb;
	timeunit 1ns;
	timeprecision 1ps;

	// The package names three operations; the fourth encoding is a no-op that must still answer.
	localparam logic [lsrv_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;

	// Random requests per idling phase; four phases make up the random part.
	localparam int PHASE_OPS = 475;

	// One entry of the pending request list. A hold entry carries no request: the sender
	// stops at it until every outstanding response has come back.
	typedef struct {
		lsrv_pkg::req_t r;
		bit             hold;
		int unsigned    gap_pct;
		int unsigned    stall_pct;
	} pending_req_t;

	logic           clk;
	logic           arst_n    = 1'b0;
	logic           req_valid = 1'b0;
	logic           req_ready;
	lsrv_pkg::req_t req       = '0;
	logic           rsp_valid;
	logic           rsp_ready = 1'b0;
	lsrv_pkg::rsp_t rsp;

	lifo_stack_with_remove_by_value dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Requests waiting to be offered, and the responses the stack owes us, oldest first.
	pending_req_t   pending_reqs[$];
	lsrv_pkg::rsp_t owed_rsps[$];

	// Our own copy of the stack contents, advanced once per accepted request.
	logic [lsrv_pkg::WORD_W-1:0] shadow_words[lsrv_pkg::DEPTH];
	int                          shadow_count = 0;

	// Receiver stall odds of the phase that the most recently sent request belongs to.
	int unsigned stall_pct = 0;

	int unsigned mismatches = 0;

	// Apply one request to the shadow stack and return the response it must produce.
	function automatic lsrv_pkg::rsp_t shadow_apply(lsrv_pkg::req_t r);
		lsrv_pkg::rsp_t o;
		int             pos;
		o.data   = '0;
		o.status = lsrv_pkg::STATUS_OK;
		case (r.mode)
			lsrv_pkg::MODE_PUSH: begin
				if (shadow_count >= lsrv_pkg::DEPTH) begin
					o.status = lsrv_pkg::STATUS_FULL;
				end else begin
					shadow_words[shadow_count] = r.value;
					shadow_count++;
				end
			end
			lsrv_pkg::MODE_POP: begin
				if (shadow_count == 0) begin
					o.status = lsrv_pkg::STATUS_EMPTY;
				end else begin
					shadow_count--;
					o.data = shadow_words[shadow_count];
				end
			end
			lsrv_pkg::MODE_REMOVE: begin
				// The search runs from the top down, so only the newest duplicate goes.
				pos = shadow_count - 1;
				while (pos >= 0 && shadow_words[pos] != r.value)
					pos--;
				if (pos < 0) begin
					o.status = lsrv_pkg::STATUS_NOTFOUND;
				end else begin
					for (int k = pos; k + 1 < shadow_count; k++)
						shadow_words[k] = shadow_words[k + 1];
					shadow_count--;
				end
			end
			default: begin
				// The unused encoding leaves the stack alone and reports success.
			end
		endcase
		o.fill = lsrv_pkg::FILL_W'(shadow_count);
		return o;
	endfunction

	// Sender. A request goes out only when the previous one has been taken, after a random
	// gap, and a hold entry keeps valid low until nothing is owed any more.
	always @(posedge clk) begin : sender
		bit           busy;
		bit           taken;
		logic         next_valid;
		pending_req_t head;
		if (arst_n) begin
			busy       = req_valid;
			taken      = req_valid && req_ready;
			next_valid = req_valid;
			if (taken) begin
				owed_rsps.push_back(shadow_apply(req));
				busy       = 1'b0;
				next_valid = 1'b0;
			end
			if (!busy && pending_reqs.size() > 0) begin
				head = pending_reqs[0];
				if (head.hold) begin
					if (!taken && owed_rsps.size() == 0)
						void'(pending_reqs.pop_front());
				end else if ($urandom_range(99) >= head.gap_pct) begin
					void'(pending_reqs.pop_front());
					req        <= head.r;
					next_valid = 1'b1;
					stall_pct  <= head.stall_pct;
				end
			end
			req_valid <= next_valid;
		end
	end

	// Receiver. Ready is dropped at random according to the current phase; each response taken
	// is checked field by field against the oldest one owed.
	always @(posedge clk) begin : receiver
		lsrv_pkg::rsp_t want;
		if (arst_n) begin
			if (rsp_valid && rsp_ready) begin
				if (owed_rsps.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: response with none outstanding: data=%h status=%0d fill=%0d",
							$realtime, rsp.data, rsp.status, rsp.fill);
				end else begin
					want = owed_rsps.pop_front();
					if (rsp.data !== want.data || rsp.status !== want.status ||
						rsp.fill !== want.fill) begin
						mismatches++;
						if (mismatches <= 10)
							$display(
								"%0t: exp data=%h st=%0d fill=%0d, got data=%h st=%0d fill=%0d",
								$realtime, want.data, want.status, want.fill,
								rsp.data, rsp.status, rsp.fill);
					end
				end
			end
			rsp_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// Odds attached to requests as they are queued.
	int unsigned fill_gap   = 0;
	int unsigned fill_stall = 0;

	task automatic queue_req(logic [lsrv_pkg::MODE_W-1:0] m, logic [lsrv_pkg::WORD_W-1:0] v);
		pending_req_t p;
		p.r.mode    = m;
		p.r.value   = v;
		p.hold      = 1'b0;
		p.gap_pct   = fill_gap;
		p.stall_pct = fill_stall;
		pending_reqs.push_back(p);
	endtask

	task automatic queue_hold();
		pending_req_t p;
		p.r         = '0;
		p.hold      = 1'b1;
		p.gap_pct   = 0;
		p.stall_pct = 0;
		pending_reqs.push_back(p);
	endtask

	initial begin : stimulus
		logic [lsrv_pkg::WORD_W-1:0] pool[6];
		int unsigned                 phase_gap[4];
		int unsigned                 phase_stall[4];
		int                          left;
		int                          burst;
		int unsigned                 style;
		int unsigned                 roll;
		logic [lsrv_pkg::MODE_W-1:0] m;
		logic [lsrv_pkg::WORD_W-1:0] v;

		// Phases: no idling, sender mostly idle, receiver mostly stalled, both lightly.
		phase_gap   = '{0, 87, 0, 11};
		phase_stall = '{0, 0, 87, 11};

		// Directed opening. Empty-stack pop and remove, the unused mode, extreme words,
		// a duplicate where only the topmost copy may go, an absent word, a removal from
		// the bottom that shifts everything above it down, and pops back to empty.
		queue_req(lsrv_pkg::MODE_POP, 32'h0000_0000);
		queue_req(lsrv_pkg::MODE_REMOVE, 32'h0000_0000);
		queue_req(MODE_UNUSED, 32'hFFFF_FFFF);
		queue_req(lsrv_pkg::MODE_PUSH, 32'h0000_0000);
		queue_req(lsrv_pkg::MODE_PUSH, 32'hFFFF_FFFF);
		queue_req(lsrv_pkg::MODE_PUSH, 32'hA5A5_A5A5);
		queue_req(lsrv_pkg::MODE_PUSH, 32'hFFFF_FFFF);
		queue_req(lsrv_pkg::MODE_REMOVE, 32'hFFFF_FFFF);
		queue_req(lsrv_pkg::MODE_REMOVE, 32'h1234_5678);
		queue_req(lsrv_pkg::MODE_REMOVE, 32'h0000_0000);
		queue_req(lsrv_pkg::MODE_POP, 32'h0000_0000);
		queue_req(lsrv_pkg::MODE_POP, 32'h0000_0000);
		// Fill to the brim, then one push too many, which must be dropped.
		for (int i = 0; i < lsrv_pkg::DEPTH; i++)
			queue_req(lsrv_pkg::MODE_PUSH, 32'h5A5A_0000 | lsrv_pkg::WORD_W'(i));
		queue_req(lsrv_pkg::MODE_PUSH, 32'h5555_AAAA);
		queue_hold();

		// Random part. Bursts lean toward pushes, pops or removes so that the stack swings
		// between empty and full, and most words come from a small pool so that removes
		// find their target and duplicates are common.
		for (int ph = 0; ph < 4; ph++) begin
			fill_gap   = phase_gap[ph];
			fill_stall = phase_stall[ph];
			pool[0] = $urandom();
			pool[1] = $urandom();
			pool[2] = $urandom();
			pool[3] = 32'h0000_0000;
			pool[4] = 32'hFFFF_FFFF;
			pool[5] = $urandom();
			left = PHASE_OPS;
			while (left > 0) begin
				burst = $urandom_range(10, 40);
				style = $urandom_range(2);
				for (int n = 0; n < burst && left > 0; n++) begin
					roll = $urandom_range(99);
					case (style)
						0: begin
							m = (roll < 60) ? lsrv_pkg::MODE_PUSH :
								(roll < 75) ? lsrv_pkg::MODE_POP :
								(roll < 95) ? lsrv_pkg::MODE_REMOVE : MODE_UNUSED;
						end
						1: begin
							m = (roll < 20) ? lsrv_pkg::MODE_PUSH :
								(roll < 70) ? lsrv_pkg::MODE_POP :
								(roll < 95) ? lsrv_pkg::MODE_REMOVE : MODE_UNUSED;
						end
						default: begin
							m = (roll < 40) ? lsrv_pkg::MODE_PUSH :
								(roll < 50) ? lsrv_pkg::MODE_POP :
								(roll < 95) ? lsrv_pkg::MODE_REMOVE : MODE_UNUSED;
						end
					endcase
					v = ($urandom_range(99) < 65) ? pool[$urandom_range(5)] : $urandom();
					queue_req(m, v);
					left--;
				end
				// Once in the middle of the phase the sender waits until every owed response has come back.
				if (left < PHASE_OPS / 2 && left + burst >= PHASE_OPS / 2)
					queue_hold();
			end
			queue_hold();
		end

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_reqs.size() != 0 || req_valid || owed_rsps.size() != 0)
			@(posedge clk);
		// A remove scans and then shifts the stack; leave room for any stray response.
		repeat (64) @(posedge clk);

		if (mismatches == 0) begin
			$display("lifo_stack_with_remove_by_value test passed");
		end else begin
			$display("lifo_stack_with_remove_by_value test failed");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest correct run, with every remove scanning the full
	// stack and both sides idling at their heaviest odds.
	initial begin
		#4_000_000;
		$display("lifo_stack_with_remove_by_value test failed");
		$finish;
	end

endmodule

>>> files.f
rtl/lsrv_pkg.sv
rtl/lsrv_ram.sv
rtl/lifo_stack_with_remove_by_value.sv
tb/lifo_stack_with_remove_by_value_tb.sv
